// ----- rtl/core/fsopa_pkg.sv -----
// Shared types, constants and codes of the fixed-size object pool allocator.
package fsopa_pkg;

  localparam int MAX_OBJECTS        = 4096;
  localparam int OBJ_HEADER_BYTES   = 8;
  localparam int FRAME_HEADER_BYTES = 16;

  localparam int ADDR_W   = 32;
  localparam int OBJ_W    = 16;
  localparam int COUNT_W  = 13;
  localparam int SLOT_W   = 17;
  localparam int STORE_AW = $clog2(MAX_OBJECTS);
  localparam int TOP_W    = $clog2(MAX_OBJECTS + 1);

  localparam logic [OBJ_W-1:0] OBJ_SIZE_RESET = 16'd16;

  // Command queue between the front and back ends; the depth is a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int DIV_STEPS = ADDR_W;
  localparam int DIVCNT_W  = $clog2(DIV_STEPS);

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_ALLOC = 2'd1;
  localparam logic [1:0] MODE_FREE  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SMALL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [2:0] CMD_LOAD  = 3'd0;
  localparam logic [2:0] CMD_ALLOC = 3'd1;
  localparam logic [2:0] CMD_FREE  = 3'd2;
  localparam logic [2:0] CMD_NOP   = 3'd3;
  localparam logic [2:0] CMD_SMALL = 3'd4;

  typedef struct packed {
    logic [1:0]        mode;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] region_len;
  } fsopa_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ADDR_W-1:0]  object_addr;
    logic [COUNT_W-1:0] free_count;
  } fsopa_out_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] count;
    logic [SLOT_W-1:0] slot;
  } fsopa_cmd_t;

endpackage

// ----- rtl/core/fixed_size_object_pool_allocator.sv -----
// Top level of the fixed-size object pool allocator.
//
//   Channel   Ports                     Transfer when
//   input     start, busy, in_item      start high and busy low at a clock edge
//   result    out_strobe, out_result    out_strobe high for one cycle
//   config    cfg_we, cfg_wdata         cfg_we high at a clock edge
//
// Free, a rejected load and an unused mode pass the front end's command register, the
// command queue and the result register; an allocate also passes the registered stack
// read. The front end takes a new item only after it has pushed the last one into the
// command queue. A load that passes the size check adds the bit-serial slot count division
// and one stack write per carved slot through the stack memory's single write port; once
// the queue fills, busy stays high. Reset is synchronous and empties the stack at once.
module fixed_size_object_pool_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  fsopa_pkg::fsopa_in_t        in_item,
  output logic                        out_strobe,
  output fsopa_pkg::fsopa_out_t       out_result,
  input  logic                        cfg_we,
  input  logic [fsopa_pkg::OBJ_W-1:0] cfg_wdata
);
  import fsopa_pkg::*;

  logic [OBJ_W-1:0] object_size_r;
  logic             push;
  fsopa_cmd_t       push_cmd;
  fsopa_cmd_t       head;
  logic             q_full;
  logic             q_empty;
  logic             pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      object_size_r <= OBJ_SIZE_RESET;
    end else if (cfg_we) begin
      object_size_r <= cfg_wdata;
    end
  end

  fsopa_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_item     (in_item),
    .object_size (object_size_r),
    .busy        (busy),
    .push        (push),
    .push_cmd    (push_cmd),
    .q_full      (q_full)
  );

  fsopa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  fsopa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_empty    (q_empty),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_result (out_result)
  );

endmodule

// ----- rtl/core/fsopa_front.sv -----
// Front end: accepts items, sizes slots, divides load regions into slot counts.
module fsopa_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  fsopa_pkg::fsopa_in_t     in_item,
  input  logic [fsopa_pkg::OBJ_W-1:0] object_size,
  output logic                     busy,
  output logic                     push,
  output fsopa_pkg::fsopa_cmd_t    push_cmd,
  input  logic                     q_full
);
  import fsopa_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]          state_r, state_nxt;
  fsopa_cmd_t          cmd_r, cmd_nxt;
  logic [ADDR_W-1:0]   quo_r, quo_nxt;
  logic [SLOT_W-1:0]   rem_r, rem_nxt;
  logic [DIVCNT_W-1:0] cnt_r, cnt_nxt;

  logic [SLOT_W:0]     slot_sum;
  logic [SLOT_W-1:0]   slot_rnd;
  logic [SLOT_W-1:0]   slot;
  logic [ADDR_W:0]     need;
  logic                too_small;
  logic [SLOT_W:0]     rem_sh;
  logic [SLOT_W+1:0]   diff;
  logic                borrow;

  // Slot size: payload plus object header, rounded up to a word.
  assign slot_sum  = {2'b00, object_size} + (SLOT_W+1)'(OBJ_HEADER_BYTES + 3);
  assign slot_rnd  = slot_sum[SLOT_W-1:0] & ~(SLOT_W'(3));
  assign slot      = (slot_rnd == '0) ? SLOT_W'(4) : slot_rnd;
  assign need      = (ADDR_W+1)'(slot) + (ADDR_W+1)'(FRAME_HEADER_BYTES);
  assign too_small = {1'b0, in_item.region_len} < need;

  // One restoring division step per cycle; the quotient shifts in behind the dividend.
  assign rem_sh = {rem_r, quo_r[ADDR_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, cmd_r.slot};
  assign borrow = diff[SLOT_W+1];

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    push      = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        if (start) begin
          cmd_nxt.slot = slot;
          cmd_nxt.addr = in_item.address;
          cmd_nxt.op   = CMD_NOP;
          quo_nxt      = '0;
          rem_nxt      = '0;
          cnt_nxt      = '0;
          state_nxt    = F_PUSH;
          unique case (in_item.mode)
            MODE_LOAD: begin
              if (too_small) begin
                cmd_nxt.op = CMD_SMALL;
              end else begin
                cmd_nxt.op   = CMD_LOAD;
                cmd_nxt.addr = in_item.address + ADDR_W'(FRAME_HEADER_BYTES);
                quo_nxt      = in_item.region_len - ADDR_W'(FRAME_HEADER_BYTES);
                state_nxt    = F_DIV;
              end
            end
            MODE_ALLOC: cmd_nxt.op = CMD_ALLOC;
            MODE_FREE: begin
              cmd_nxt.op   = CMD_FREE;
              cmd_nxt.addr = in_item.address - ADDR_W'(OBJ_HEADER_BYTES);
            end
            default: cmd_nxt.op = CMD_NOP;
          endcase
        end
      end
      F_DIV: begin
        rem_nxt = borrow ? rem_sh[SLOT_W-1:0] : diff[SLOT_W-1:0];
        quo_nxt = {quo_r[ADDR_W-2:0], ~borrow};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIVCNT_W'(DIV_STEPS - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          push      = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    push_cmd       = cmd_r;
    push_cmd.count = quo_r;
  end

  assign busy = (state_r != F_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cmd_r <= cmd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

// ----- rtl/core/fsopa_queue.sv -----
// Short command queue between the front and back ends.
module fsopa_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  fsopa_pkg::fsopa_cmd_t push_cmd,
  input  logic                  pop,
  output fsopa_pkg::fsopa_cmd_t head,
  output logic                  full,
  output logic                  empty
);
  import fsopa_pkg::*;

  fsopa_cmd_t        ent_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full    = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- rtl/core/fsopa_back.sv -----
// Back end: free-slot stack memory, stack pointer and result register.
module fsopa_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fsopa_pkg::fsopa_cmd_t head,
  input  logic                  q_empty,
  output logic                  pop,
  output logic                  out_strobe,
  output fsopa_pkg::fsopa_out_t out_result
);
  import fsopa_pkg::*;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_READ = 2'd1;
  localparam logic [1:0] B_LOAD = 2'd2;

  logic [ADDR_W-1:0]   store_mem [MAX_OBJECTS];
  logic [ADDR_W-1:0]   rd_data_r;

  logic [1:0]          state_r, state_nxt;
  logic [TOP_W-1:0]    top_r, top_nxt;
  logic [ADDR_W-1:0]   ld_addr_r, ld_addr_nxt;
  logic [TOP_W-1:0]    ld_left_r, ld_left_nxt;
  logic [SLOT_W-1:0]   ld_slot_r, ld_slot_nxt;
  logic                strobe_r, strobe_nxt;
  fsopa_out_t          res_r, res_nxt;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_wdata;
  logic                mem_re;
  logic [TOP_W-1:0]    top_dec;
  logic [TOP_W-1:0]    top_inc;
  logic [ADDR_W:0]     ld_total;
  logic                ld_over;

  assign top_dec  = top_r - 1'b1;
  assign top_inc  = top_r + 1'b1;
  assign ld_total = {1'b0, head.count} + (ADDR_W+1)'(top_r);
  assign ld_over  = ld_total > (ADDR_W+1)'(MAX_OBJECTS);

  always_comb begin
    state_nxt   = state_r;
    top_nxt     = top_r;
    ld_addr_nxt = ld_addr_r;
    ld_left_nxt = ld_left_r;
    ld_slot_nxt = ld_slot_r;
    pop         = 1'b0;
    mem_we      = 1'b0;
    mem_wdata   = ld_addr_r;
    mem_re      = 1'b0;
    strobe_nxt  = 1'b0;
    res_nxt     = res_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          pop                 = 1'b1;
          res_nxt.status      = ST_OK;
          res_nxt.object_addr = '0;
          res_nxt.free_count  = COUNT_W'(top_r);
          strobe_nxt          = 1'b1;
          case (head.op)
            CMD_SMALL: res_nxt.status = ST_SMALL;
            CMD_ALLOC: begin
              if (top_r == '0) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                mem_re     = 1'b1;
                top_nxt    = top_dec;
                strobe_nxt = 1'b0;
                state_nxt  = B_READ;
              end
            end
            CMD_FREE: begin
              if (top_r >= TOP_W'(MAX_OBJECTS)) begin
                res_nxt.status = ST_FULL;
              end else begin
                mem_we             = 1'b1;
                mem_wdata          = head.addr;
                top_nxt            = top_inc;
                res_nxt.free_count = COUNT_W'(top_inc);
              end
            end
            CMD_LOAD: begin
              if (ld_over) begin
                res_nxt.status = ST_FULL;
              end else if (head.count != '0) begin
                ld_addr_nxt = head.addr;
                ld_left_nxt = TOP_W'(head.count);
                ld_slot_nxt = head.slot;
                strobe_nxt  = 1'b0;
                state_nxt   = B_LOAD;
              end
            end
            default: ;
          endcase
        end
      end
      B_READ: begin
        strobe_nxt          = 1'b1;
        res_nxt.status      = ST_OK;
        res_nxt.object_addr = rd_data_r + ADDR_W'(OBJ_HEADER_BYTES);
        res_nxt.free_count  = COUNT_W'(top_r);
        state_nxt           = B_IDLE;
      end
      B_LOAD: begin
        // One slot address is pushed per cycle, lowest address first.
        mem_we      = 1'b1;
        top_nxt     = top_inc;
        ld_addr_nxt = ld_addr_r + ADDR_W'(ld_slot_r);
        ld_left_nxt = ld_left_r - 1'b1;
        if (ld_left_r == TOP_W'(1)) begin
          strobe_nxt          = 1'b1;
          res_nxt.status      = ST_OK;
          res_nxt.object_addr = '0;
          res_nxt.free_count  = COUNT_W'(top_inc);
          state_nxt           = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[top_r[STORE_AW-1:0]] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= store_mem[top_dec[STORE_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      top_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      top_r    <= top_nxt;
      strobe_r <= strobe_nxt;
    end
    ld_addr_r <= ld_addr_nxt;
    ld_left_r <= ld_left_nxt;
    ld_slot_r <= ld_slot_nxt;
    res_r     <= res_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_result = res_r;

endmodule

// ----- rtl/core/fsopa_checker.sv -----
// Port-level assertions for the object pool allocator, bound to its top level.
module fsopa_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_strobe,
  input fsopa_pkg::fsopa_out_t out_result
);
  import fsopa_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an input transfer");

  a_addr_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_result.status != ST_OK) |-> (out_result.object_addr == '0))
    else $error("nonzero object address on a failed result");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_result.status == ST_EMPTY) |-> (out_result.free_count == '0))
    else $error("pool empty reported with a nonzero free count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_result.free_count <= COUNT_W'(MAX_OBJECTS)))
    else $error("free count above the pool capacity");

endmodule

bind fixed_size_object_pool_allocator fsopa_checker u_fsopa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_result (out_result)
);
